### design/fragment_event_builder_defines.svh
// assertion macros shared by the event builder modules
`ifndef FRAGMENT_EVENT_BUILDER_DEFINES_SVH
`define FRAGMENT_EVENT_BUILDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FEB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FEB_ASSERT_SAME(lbl, ante, cons, msg)
`define FEB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/feb_pkg.sv
// shared constants, codes and control types of the event builder
`timescale 1ns / 1ps
package feb_pkg;
  localparam int SEQ_W      = 48;
  localparam int TBL_N      = 32;
  localparam int IDX_W      = $clog2(TBL_N);
  localparam int CNT_W      = $clog2(TBL_N + 1);
  localparam int DCNT_W     = $clog2(SEQ_W);
  localparam int TIME_W     = 64;
  localparam int FRAG_W     = 8;
  localparam int MAXI_W     = 6;
  localparam int MOD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FLUSH  = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_FLUSHED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OK_FULL  = 2'd1;
  localparam logic [1:0] ST_REJ_QUE  = 2'd2;
  localparam logic [1:0] ST_REJ_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EOR  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_DIV, S_SCAN, S_CHECK, S_REQ, S_ENTRY, S_STAT, S_FSCAN, S_FEMIT
  } state_t;

  typedef enum logic [1:0] {SEL_STAT, SEL_REQ, SEL_EVT, SEL_FLUSH} out_sel_t;

  typedef struct packed {
    logic       ld_in;
    logic       start_run;
    logic       div_step;
    logic       scan_step;
    logic       latch_full;
    logic       upd_highest;
    logic       write_entry;
    logic       mark_done;
    logic       clr_table;
    logic       emit;
    out_sel_t   emit_sel;
    logic [1:0] emit_status;
    logic       emit_allf;
    logic       emit_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic qf;
    logic div_last;
    logic scan_last;
    logic hit;
    logic full;
    logic full_latched;
    logic req_go;
    logic complete;
    logic best;
    logic out_free;
  } dp_stat_t;
endpackage

### design/feb_dpath.sv
// datapath: config, divider, event table, scan unit and output register
`timescale 1ns / 1ps
`include "fragment_event_builder_defines.svh"
module feb_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [feb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [feb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]                    in_cmd,
  input  logic [feb_pkg::SEQ_W-1:0]      in_seq_num,
  input  logic [feb_pkg::TIME_W-1:0]     in_frag_time,
  input  logic                          in_queue_full,
  input  feb_pkg::ctrl_cmd_t            cmd,
  output feb_pkg::dp_stat_t             stat,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [1:0]                    out_kind,
  output logic [1:0]                    out_status,
  output logic [feb_pkg::SEQ_W-1:0]      out_event_id,
  output logic [feb_pkg::SEQ_W-1:0]      out_first_seq,
  output logic [feb_pkg::FRAG_W-1:0]     out_frag_count,
  output logic [feb_pkg::TIME_W-1:0]     out_req_time,
  output logic                          out_all_flushed,
  output logic                          out_last
);
  import feb_pkg::*;

  logic [FRAG_W-1:0] fpe_r;
  logic [MAXI_W-1:0] maxi_r;
  logic [MOD_W-1:0]  mod_r;
  logic              reqen_r, eor_r;

  logic [SEQ_W-1:0]  seq_r;
  logic [TIME_W-1:0] time_r;
  logic              qf_r;
  logic [SEQ_W-1:0]  lfs_r, hs_r;

  logic [SEQ_W-1:0]  dq_r;
  logic [MOD_W-1:0]  rem_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic [TBL_N-1:0]  valid_r, done_r;
  logic [SEQ_W-1:0]  ent_id_r    [TBL_N];
  logic [SEQ_W-1:0]  ent_first_r [TBL_N];
  logic [FRAG_W-1:0] ent_cnt_r   [TBL_N];
  logic [CNT_W-1:0]  stored_r;

  logic [IDX_W-1:0]  sidx_r, hit_idx_r, free_idx_r, best_idx_r;
  logic              hit_r, free_r, best_r, full_r;
  logic [SEQ_W-1:0]  best_id_r;

  logic              out_valid_r, out_allf_r, out_last_r;
  logic [1:0]        out_kind_r, out_status_r;
  logic [SEQ_W-1:0]  out_id_r, out_first_r;
  logic [FRAG_W-1:0] out_cnt_r;
  logic [TIME_W-1:0] out_time_r;

  logic [MOD_W-1:0]  divisor;
  logic [MOD_W:0]    rem_sh, rem_sub;
  logic              ge;
  logic [SEQ_W-1:0]  ev_id;
  logic [IDX_W-1:0]  tgt;
  logic [FRAG_W-1:0] old_cnt, new_cnt;
  logic [SEQ_W-1:0]  first_sel;
  logic              complete, raised, full, out_free, scan_init;

  always_comb begin
    divisor   = (mod_r == '0) ? MOD_W'(1) : mod_r;
    rem_sh    = {rem_r, dq_r[SEQ_W-1]};
    rem_sub   = rem_sh - {1'b0, divisor};
    ge        = (rem_sh >= {1'b0, divisor});
    ev_id     = dq_r + SEQ_W'(1);
    tgt       = hit_r ? hit_idx_r : free_idx_r;
    old_cnt   = hit_r ? ent_cnt_r[hit_idx_r] : '0;
    new_cnt   = (old_cnt == '1) ? old_cnt : old_cnt + FRAG_W'(1);
    complete  = (new_cnt == fpe_r);
    first_sel = hit_r ? ent_first_r[hit_idx_r] : seq_r;
    raised    = (seq_r > hs_r);
    full      = (stored_r >= CNT_W'(maxi_r)) || !free_r;
    out_free  = !out_valid_r || !out_stall;
    scan_init = cmd.ld_in || cmd.mark_done;

    stat.qf           = qf_r;
    stat.div_last     = (dcnt_r == DCNT_W'(SEQ_W - 1));
    stat.scan_last    = (sidx_r == IDX_W'(TBL_N - 1));
    stat.hit          = hit_r;
    stat.full         = full;
    stat.full_latched = full_r;
    stat.req_go       = reqen_r && (raised || eor_r);
    stat.complete     = complete;
    stat.best         = best_r;
    stat.out_free     = out_free;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpe_r   <= FRAG_W'(1);
      maxi_r  <= MAXI_W'(32);
      mod_r   <= MOD_W'(1);
      reqen_r <= 1'b0;
      eor_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FPE:  fpe_r   <= cfg_wdata[FRAG_W-1:0];
        CFG_MAXI: maxi_r  <= cfg_wdata[MAXI_W-1:0];
        CFG_MOD:  mod_r   <= cfg_wdata[MOD_W-1:0];
        CFG_REQ:  reqen_r <= cfg_wdata[0];
        CFG_EOR:  eor_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control state: counters, valid and done bits, scan flags, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfs_r       <= '0;
      hs_r        <= '0;
      valid_r     <= '0;
      done_r      <= '0;
      stored_r    <= '0;
      dcnt_r      <= '0;
      sidx_r      <= '0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      best_r      <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_run) begin
        lfs_r <= '0;
        hs_r  <= '0;
      end
      if (cmd.upd_highest && raised) hs_r <= seq_r;
      if (cmd.ld_in) begin
        dcnt_r <= '0;
        done_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      if (scan_init) begin
        sidx_r <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        best_r <= 1'b0;
      end else if (cmd.scan_step) begin
        sidx_r <= sidx_r + IDX_W'(1);
        if (valid_r[sidx_r] && ent_id_r[sidx_r] == ev_id) hit_r <= 1'b1;
        if (!valid_r[sidx_r]) free_r <= 1'b1;
        if (valid_r[sidx_r] && !done_r[sidx_r] &&
            (!best_r || ent_id_r[sidx_r] < best_id_r)) best_r <= 1'b1;
      end
      if (cmd.mark_done) done_r[best_idx_r] <= 1'b1;
      if (cmd.latch_full) full_r <= full;
      if (cmd.write_entry) begin
        valid_r[tgt] <= !complete;
        stored_r     <= stored_r + CNT_W'(!hit_r) - CNT_W'(complete);
      end
      if (cmd.clr_table) begin
        valid_r  <= '0;
        stored_r <= '0;
        lfs_r    <= hs_r;
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      seq_r  <= in_seq_num;
      time_r <= in_frag_time;
      qf_r   <= in_queue_full && (in_cmd == CMD_INSERT);
      dq_r   <= in_seq_num - SEQ_W'(1) - lfs_r;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      // one restoring quotient bit per cycle
      dq_r  <= {dq_r[SEQ_W-2:0], ge};
      rem_r <= ge ? rem_sub[MOD_W-1:0] : rem_sh[MOD_W-1:0];
    end
    if (cmd.scan_step) begin
      if (valid_r[sidx_r] && ent_id_r[sidx_r] == ev_id) hit_idx_r <= sidx_r;
      if (!valid_r[sidx_r] && !free_r) free_idx_r <= sidx_r;
      if (valid_r[sidx_r] && !done_r[sidx_r] &&
          (!best_r || ent_id_r[sidx_r] < best_id_r)) begin
        best_idx_r <= sidx_r;
        best_id_r  <= ent_id_r[sidx_r];
      end
    end
    if (cmd.write_entry) begin
      ent_cnt_r[tgt] <= new_cnt;
      if (!hit_r) begin
        ent_id_r[tgt]    <= ev_id;
        ent_first_r[tgt] <= seq_r;
      end
    end
    if (cmd.emit) begin
      out_kind_r   <= KIND_STATUS;
      out_status_r <= '0;
      out_id_r     <= '0;
      out_first_r  <= '0;
      out_cnt_r    <= '0;
      out_time_r   <= '0;
      out_allf_r   <= cmd.emit_allf;
      out_last_r   <= cmd.emit_last;
      case (cmd.emit_sel)
        SEL_STAT: out_status_r <= cmd.emit_status;
        SEL_REQ: begin
          out_kind_r <= KIND_REQUEST;
          out_id_r   <= seq_r;
          out_time_r <= time_r;
        end
        SEL_EVT: begin
          out_kind_r  <= KIND_DONE;
          out_id_r    <= ev_id;
          out_first_r <= first_sel;
          out_cnt_r   <= new_cnt;
        end
        SEL_FLUSH: begin
          out_kind_r  <= KIND_FLUSHED;
          out_id_r    <= best_id_r;
          out_first_r <= ent_first_r[best_idx_r];
          out_cnt_r   <= ent_cnt_r[best_idx_r];
        end
        default: ;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_event_id    = out_id_r;
  assign out_first_seq   = out_first_r;
  assign out_frag_count  = out_cnt_r;
  assign out_req_time    = out_time_r;
  assign out_all_flushed = out_allf_r;
  assign out_last        = out_last_r;

  `FEB_ASSERT_SAME(a_fill_matches, 1'b1, $countones(valid_r) == int'(stored_r), "fill count off")
  `FEB_ASSERT_SAME(a_done_needs_best, cmd.mark_done, best_r, "flush marks without a pick")
  `FEB_ASSERT_NEXT(a_clear_empties, cmd.clr_table, valid_r == '0, "table not cleared")
endmodule

### design/feb_ctrl.sv
// controller state machine of the event builder
`timescale 1ns / 1ps
`include "fragment_event_builder_defines.svh"
module feb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  output logic               in_stall,
  input  feb_pkg::dp_stat_t  stat,
  output feb_pkg::ctrl_cmd_t cmd
);
  import feb_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.ld_in = 1'b1;
          case (in_cmd)
            CMD_INSERT: state_nxt = S_INS;
            CMD_FLUSH:  state_nxt = S_FSCAN;
            CMD_START:  cmd.start_run = 1'b1;
            default: ;
          endcase
        end
      end
      S_INS: begin
        if (!stat.qf) begin
          state_nxt = S_DIV;
        end else if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_STAT;
          cmd.emit_status = ST_REJ_QUE;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.latch_full = 1'b1;
        if (!(stat.full && !stat.hit)) begin
          state_nxt = S_REQ;
        end else if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_STAT;
          cmd.emit_status = ST_REJ_FULL;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_REQ: begin
        if (!stat.req_go) begin
          cmd.upd_highest = 1'b1;
          state_nxt       = S_ENTRY;
        end else if (stat.out_free) begin
          cmd.upd_highest = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_REQ;
          state_nxt       = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (!stat.complete) begin
          cmd.write_entry = 1'b1;
          state_nxt       = S_STAT;
        end else if (stat.out_free) begin
          cmd.write_entry = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_EVT;
          state_nxt       = S_STAT;
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_sel    = SEL_STAT;
          cmd.emit_status = stat.full_latched ? ST_OK_FULL : ST_OK;
          cmd.emit_last   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_FSCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = S_FEMIT;
      end
      S_FEMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_allf = 1'b1;
          if (stat.best) begin
            // lowest remaining id goes out, then rescan
            cmd.emit_sel  = SEL_FLUSH;
            cmd.mark_done = 1'b1;
            state_nxt     = S_FSCAN;
          end else begin
            cmd.emit_sel    = SEL_STAT;
            cmd.emit_status = ST_OK;
            cmd.emit_last   = 1'b1;
            cmd.clr_table   = 1'b1;
            state_nxt       = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `FEB_ASSERT_SAME(a_emit_free, cmd.emit, stat.out_free, "word loaded over a waiting word")
  `FEB_ASSERT_NEXT(a_idle_holds, state_r == S_IDLE && !accept, state_r == S_IDLE, "left idle")
  `FEB_ASSERT_SAME(a_last_to_idle, cmd.emit && cmd.emit_last, state_nxt == S_IDLE,
                   "last word without return to idle")
endmodule

### design/fragment_event_builder.sv
// Fragment event builder: groups fragments into events by normalized id.
// Input channel in_*: one word per command (insert, flush, start run),
// accepted when in_valid is high and in_stall low. Output channel out_*:
// result words, taken when out_valid is high and out_stall low; out_last
// marks the final word of a command. Start run and unused commands give no
// words. Configuration is written through cfg_we/cfg_index/cfg_wdata while
// the block is idle.
// One command is worked at a time; in_stall is high until its last word is
// loaded into the output register. An insert loads its inputs on accept,
// tests queue_full, runs the bit-serial divide by the modulus, scans the
// table, then decides and emits its words in the check, request, entry and
// status states. A queue_full reject ends after the queue_full test, a
// store-full reject after the table scan. A flush does one table scan per word.
// Words wait in a single output register; a stall of the receiver holds it
// and the controller waits for it to drain, adding the stalled cycles.
// Reset (rst_n low, synchronous) empties the table, clears the sequence
// counters and the output, and restores the default configuration.
`timescale 1ns / 1ps
module fragment_event_builder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [feb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [feb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_cmd,
  input  logic [feb_pkg::SEQ_W-1:0]      in_seq_num,
  input  logic [feb_pkg::TIME_W-1:0]     in_frag_time,
  input  logic                          in_queue_full,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [1:0]                    out_status,
  output logic [feb_pkg::SEQ_W-1:0]      out_event_id,
  output logic [feb_pkg::SEQ_W-1:0]      out_first_seq,
  output logic [feb_pkg::FRAG_W-1:0]     out_frag_count,
  output logic [feb_pkg::TIME_W-1:0]     out_req_time,
  output logic                          out_all_flushed,
  output logic                          out_last
);
  import feb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  feb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  feb_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cmd          (in_cmd),
    .in_seq_num      (in_seq_num),
    .in_frag_time    (in_frag_time),
    .in_queue_full   (in_queue_full),
    .cmd             (cmd),
    .stat            (stat),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_event_id    (out_event_id),
    .out_first_seq   (out_first_seq),
    .out_frag_count  (out_frag_count),
    .out_req_time    (out_req_time),
    .out_all_flushed (out_all_flushed),
    .out_last        (out_last)
  );
endmodule

### sim/fragment_event_builder_test.sv
// testbench for the fragment event builder: directed table, random traffic, predictor check
`timescale 1ns / 1ps
module fragment_event_builder_test;
  import feb_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [47:0] event_id;
    logic [47:0] first_seq;
    logic [7:0]  frag_count;
    logic [63:0] req_time;
    logic        all_flushed;
    logic        last;
  } word_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [47:0] seq;
    logic [63:0] ftime;
    logic        qf;
    bit          typed;   // expected status word typed in below
    logic [1:0]  status;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 0, in_queue_full = 0;
  logic [1:0] in_cmd = '0;
  logic [47:0] in_seq_num = '0;
  logic [63:0] in_frag_time = '0;
  logic in_stall, out_valid, out_stall = 0;
  logic [1:0] out_kind, out_status;
  logic [47:0] out_event_id, out_first_seq;
  logic [7:0] out_frag_count;
  logic [63:0] out_req_time;
  logic out_all_flushed, out_last;

  fragment_event_builder u_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  fpe;
  logic [5:0]  maxi;
  logic [15:0] modulus;
  logic        req_en, eor;
  bit          tv[32];
  logic [47:0] t_id[32], t_first[32];
  logic [7:0]  t_cnt[32];
  logic [47:0] last_flushed, highest;
  int          stored;

  word_t expected_words[$];
  int errors = 0;
  longint unsigned cycles = 0;
  int send_idle = 0, recv_stall = 0;

  function automatic word_t mk(logic [1:0] k);
    word_t w;
    w = '{kind: k, status: ST_OK, event_id: '0, first_seq: '0, frag_count: '0,
          req_time: '0, all_flushed: 1'b0, last: 1'b0};
    return w;
  endfunction

  function automatic void queue_word(input word_t w);
    expected_words = {expected_words, w};
  endfunction

  task automatic predict_builder(input logic [1:0] cmd, input logic [47:0] seq,
                                 input logic [63:0] ft, input logic qf);
    word_t w;
    logic [47:0] id, dv;
    int hit, fs, best, n0;
    bit full, raised;
    bit done[32];
    hit = -1; fs = -1; n0 = expected_words.size();
    if (cmd == CMD_INSERT) begin
      w = mk(KIND_STATUS);
      w.last = 1;
      if (qf) begin
        w.status = ST_REJ_QUE;
        queue_word(w);
        return;
      end
      dv = (modulus == 0) ? 48'd1 : {32'd0, modulus};
      id = (seq - (48'd1 + last_flushed)) / dv + 48'd1;
      for (int i = 0; i < 32; i++)
        if (tv[i]) begin
          if (t_id[i] == id) hit = i;
        end else if (fs < 0) fs = i;
      full = (stored >= maxi) || fs < 0;
      if (full && hit < 0) begin
        w.status = ST_REJ_FULL;
        queue_word(w);
        return;
      end
      raised = seq > highest;
      if (raised) highest = seq;
      if (req_en && (raised || eor)) begin
        w = mk(KIND_REQUEST);
        w.event_id = seq;
        w.req_time = ft;
        queue_word(w);
      end
      if (hit < 0) begin
        hit = fs;
        tv[hit] = 1; t_id[hit] = id; t_first[hit] = seq; t_cnt[hit] = 0;
        stored++;
      end
      if (t_cnt[hit] != 8'd255) t_cnt[hit]++;
      if (t_cnt[hit] == fpe) begin
        w = mk(KIND_DONE);
        w.event_id = id; w.first_seq = t_first[hit]; w.frag_count = t_cnt[hit];
        queue_word(w);
        tv[hit] = 0;
        stored--;
      end
      w = mk(KIND_STATUS);
      w.status = full ? ST_OK_FULL : ST_OK;
      w.last = 1;
      queue_word(w);
    end else if (cmd == CMD_FLUSH) begin
      done = '{default: 0};
      forever begin
        best = -1;
        for (int i = 0; i < 32; i++)
          if (tv[i] && !done[i] && (best < 0 || t_id[i] < t_id[best])) best = i;
        if (best < 0) break;
        done[best] = 1;
        w = mk(KIND_FLUSHED);
        w.event_id = t_id[best]; w.first_seq = t_first[best];
        w.frag_count = t_cnt[best]; w.all_flushed = 1;
        queue_word(w);
      end
      w = mk(KIND_STATUS);
      w.all_flushed = 1; w.last = 1;
      queue_word(w);
      tv = '{default: 0};
      stored = 0;
      last_flushed = highest;
    end else if (cmd == CMD_START) begin
      last_flushed = '0;
      highest = '0;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    word_t w;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d status=%0d id=%h", $time,
                 out_kind, out_status, out_event_id);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if ({out_kind, out_status, out_event_id, out_first_seq, out_frag_count,
             out_req_time, out_all_flushed, out_last} !==
            {w.kind, w.status, w.event_id, w.first_seq, w.frag_count,
             w.req_time, w.all_flushed, w.last}) begin
          $display("%0t: mismatch expected kind=%0d st=%0d id=%h first=%h cnt=%0d t=%h af=%b l=%b",
                   $time, w.kind, w.status, w.event_id, w.first_seq, w.frag_count,
                   w.req_time, w.all_flushed, w.last);
          $display("%0t:          actual kind=%0d st=%0d id=%h first=%h cnt=%0d t=%h af=%b l=%b",
                   $time, out_kind, out_status, out_event_id, out_first_seq,
                   out_frag_count, out_req_time, out_all_flushed, out_last);
          errors++;
        end
      end
    end
    out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk)
    if (cycles > 64'd4_000_000) begin
      $display("== FAIL ==");
      $finish;
    end

  // each write drops cfg_we again before the next, keeping the enable pulses apart
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val[15:0];
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    case (idx)
      CFG_FPE:  fpe = val[7:0];
      CFG_MAXI: maxi = val[5:0];
      CFG_MOD:  modulus = val[15:0];
      CFG_REQ:  req_en = val[0];
      CFG_EOR:  eor = val[0];
      default: ;
    endcase
  endtask

  // drains results, then lets a start-run or an in-flight word settle
  task automatic wait_idle();
    in_valid <= 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // valid stays up after an accept until the next word or an idle cycle
  task automatic send_word(input logic [1:0] cmd, input logic [47:0] seq,
                           input logic [63:0] ft, input logic qf);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_cmd <= cmd; in_seq_num <= seq; in_frag_time <= ft;
    in_queue_full <= qf;
    predict_builder(cmd, seq, ft, qf);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  row_t dir_rows[] = '{
    '{CMD_INSERT, 48'd5, 64'd1, 1'b1, 1, ST_REJ_QUE},
    '{CMD_INSERT, 48'd1, 64'd0, 1'b0, 0, ST_OK},
    '{CMD_INSERT, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 0, ST_OK},
    '{CMD_INSERT, 48'd0, 64'h8000_0000_0000_0000, 1'b0, 0, ST_OK},
    '{CMD_FLUSH, 48'd0, 64'd0, 1'b0, 0, ST_OK},
    '{CMD_START, 48'd0, 64'd0, 1'b0, 0, ST_OK},
    '{2'd3, 48'hABC, 64'd7, 1'b0, 0, ST_OK},
    '{CMD_INSERT, 48'd10, 64'd3, 1'b0, 0, ST_OK},
    '{CMD_INSERT, 48'd11, 64'd4, 1'b0, 0, ST_OK},
    '{CMD_INSERT, 48'd12, 64'd5, 1'b1, 1, ST_REJ_QUE},
    '{CMD_INSERT, 48'd40, 64'd6, 1'b0, 0, ST_OK},
    '{CMD_INSERT, 48'd41, 64'd6, 1'b0, 0, ST_OK},
    '{CMD_FLUSH, 48'd0, 64'd0, 1'b0, 0, ST_OK},
    '{CMD_INSERT, 48'd3, 64'd9, 1'b0, 0, ST_OK},
    '{CMD_START, 48'd0, 64'd0, 1'b0, 0, ST_OK}
  };

  int phase_idle[4] = '{0, 82, 0, 9};
  int phase_stall[4] = '{0, 0, 82, 9};

  initial begin
    word_t w;
    logic [47:0] base, s;
    int r, nf;
    fpe = 1; maxi = 32; modulus = 1; req_en = 0; eor = 0;
    tv = '{default: 0}; last_flushed = '0; highest = '0; stored = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part: defaults first, then fragments of two with requests
    foreach (dir_rows[i]) begin
      if (i == 7) begin
        wait_idle();
        write_reg(CFG_FPE, 2); write_reg(CFG_REQ, 1); write_reg(CFG_MOD, 0);
      end
      if (dir_rows[i].typed) begin
        // status of a rejected fragment is plain to see
        w = mk(KIND_STATUS); w.status = dir_rows[i].status; w.last = 1;
        send_word(dir_rows[i].cmd, dir_rows[i].seq, dir_rows[i].ftime, 1'b1);
        if (expected_words[$] != w) begin
          $display("%0t: table row %0d expectation differs", $time, i);
          errors++;
        end
      end else
        send_word(dir_rows[i].cmd, dir_rows[i].seq, dir_rows[i].ftime, dir_rows[i].qf);
    end
    // table fill limits: max_incomplete of one, then zero fragments per event
    wait_idle();
    write_reg(CFG_MAXI, 1); write_reg(CFG_EOR, 1); write_reg(CFG_FPE, 3);
    send_word(CMD_INSERT, 48'd2, 64'd1, 0);
    send_word(CMD_INSERT, 48'd9, 64'd2, 0);
    send_word(CMD_INSERT, 48'd2, 64'd3, 0);
    wait_idle();
    write_reg(CFG_FPE, 0); write_reg(CFG_MAXI, 63);
    for (int i = 0; i < 34; i++) send_word(CMD_INSERT, 48'd100 + i, i, 0);
    send_word(CMD_FLUSH, 0, 0, 0);

    // random part in four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      send_idle = phase_idle[ph]; recv_stall = phase_stall[ph];
      write_reg(CFG_FPE, (ph == 3) ? 255 : $urandom_range(1, 4));
      write_reg(CFG_MAXI, (ph == 2) ? 63 : $urandom_range(1, 32));
      write_reg(CFG_MOD, (ph == 1) ? 65535 : $urandom_range(1, 4));
      write_reg(CFG_REQ, ph != 0);
      write_reg(CFG_EOR, ph[0]);
      base = highest;
      nf = 0;
      while (nf < 95) begin
        r = $urandom_range(99);
        if (r < 3) send_word(CMD_FLUSH, rand64(), rand64(), $urandom_range(1));
        else if (r < 5) begin
          send_word(CMD_START, rand64(), rand64(), $urandom_range(1));
          base = '0;
        end else if (r < 7) send_word(2'd3, rand64(), rand64(), $urandom_range(1));
        else if (r < 12) begin
          send_word(CMD_INSERT, rand64(), rand64(), $urandom_range(1));
          nf++;
        end else begin
          // mostly nearby sequence numbers so fragments share events
          s = base + $urandom_range(1, 40);
          send_word(CMD_INSERT, s, rand64(), $urandom_range(99) < 5);
          if ($urandom_range(3) == 0) base = base + $urandom_range(1, 8);
          nf++;
        end
      end
      send_word(CMD_FLUSH, 0, 0, 0);
    end

    in_valid <= 0;
    recv_stall = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
